@@ design/waypoint_path_follower_3d_unit_assert.svh @@
// Assertion macros for the waypoint path follower.
`ifndef WAYPOINT_PATH_FOLLOWER_3D_UNIT_ASSERT_SVH
`define WAYPOINT_PATH_FOLLOWER_3D_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WPF3D_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define WPF3D_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/wpf3d_pkg.sv @@
// Shared types, widths and codes of the waypoint path follower.
package wpf3d_pkg;
	localparam int MAX_WAYPOINTS_DEF = 16;
	localparam int POS_WIDTH_DEF     = 32;

	localparam int COORD_W   = 32;
	localparam int SLOT_W    = 4;
	localparam int TGT_OUT_W = 4;
	localparam int PLEN_W    = 5;
	localparam int DIR_W     = 18;
	localparam int FRAC_W    = 16;
	localparam int DIGIT_W   = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_STEP    = 2'd0,
		OP_LOAD    = 2'd1,
		OP_RESTART = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Z  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PATH_LEN = 3'd6;
endpackage

@@ design/wpf3d_ifs.sv @@
// Channel interfaces: command words in, position words out, register writes.
interface wpf3d_cmd_if;
	logic                                valid;
	logic                                ready;
	wpf3d_pkg::op_t                      opcode;
	logic [wpf3d_pkg::SLOT_W-1:0]        waypoint_slot;
	logic signed [wpf3d_pkg::COORD_W-1:0] coord_x;
	logic signed [wpf3d_pkg::COORD_W-1:0] coord_y;
	logic signed [wpf3d_pkg::COORD_W-1:0] coord_z;
	modport source (output valid, opcode, waypoint_slot, coord_x, coord_y, coord_z,
		input ready);
	modport sink (input valid, opcode, waypoint_slot, coord_x, coord_y, coord_z,
		output ready);
endinterface

interface wpf3d_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [wpf3d_pkg::COORD_W-1:0] new_x;
	logic signed [wpf3d_pkg::COORD_W-1:0] new_y;
	logic signed [wpf3d_pkg::COORD_W-1:0] new_z;
	logic [wpf3d_pkg::TGT_OUT_W-1:0]      target_now;
	modport source (output valid, new_x, new_y, new_z, target_now, input ready);
	modport sink (input valid, new_x, new_y, new_z, target_now, output ready);
endinterface

interface wpf3d_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wpf3d_pkg::CFG_IDX_W-1:0] index;
	logic [wpf3d_pkg::COORD_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/wpf3d_mac.sv @@
// Shared multiply-accumulate: one multiplicand times one 16-bit digit per cycle while en is high.
module wpf3d_mac #(
	parameter int MW = 33,
	parameter int AW = 68,
	parameter int KW = 2
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          first,
	input  logic [MW-1:0]                 a,
	input  logic [wpf3d_pkg::DIGIT_W-1:0] digit,
	input  logic [KW-1:0]                 k,
	output logic [AW-1:0]                 acc
);
	logic [MW+wpf3d_pkg::DIGIT_W-1:0] pp;
	logic [AW-1:0]                    pp_sh;
	logic [AW-1:0]                    acc_q;

	// Form the partial product and place it at its digit position
	assign pp    = a * digit;
	assign pp_sh = AW'(pp) << {k, 4'b0000};

	// Load on the first digit, accumulate after
	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= first ? pp_sh : acc_q + pp_sh;
		end
	end

	assign acc = acc_q;
endmodule

@@ design/waypoint_path_follower_3d_unit.sv @@
// Top level of the waypoint path follower: sequencer, waypoint table, datapath.
//
// Use: command words arrive on cmd (opcode, slot, coordinates), one result
// word per command leaves on res, registers are written on cfg (always ready,
// to be used only while no command is in flight).
// Load, no-op, and a step or restart with an empty path go straight to the result.
// A step runs its three axis moves and six squared distances through one
// 16-bit-digit multiply-accumulate unit. On a waypoint change, and on a restart
// with a non-empty path, one compare-subtract unit runs the bit-serial square root
// of (POS_WIDTH+1) + 1 root bits and then three 17-bit restoring divides.
// A zero-length vector skips the divides.
// cmd is ready only while the sequencer is idle. A finished word waits in the
// output register while the next command is accepted; if res stalls, the
// following result is held until the output register frees up.
// Reset clears the target index, the direction and all registers; the
// waypoint table is undefined until loaded.
`include "waypoint_path_follower_3d_unit_assert.svh"

module waypoint_path_follower_3d_unit #(
	parameter int MAX_WAYPOINTS = wpf3d_pkg::MAX_WAYPOINTS_DEF,
	parameter int POS_WIDTH     = wpf3d_pkg::POS_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wpf3d_cmd_if.sink  cmd,
	wpf3d_res_if.source res,
	wpf3d_cfg_if.sink  cfg
);
	localparam int PW     = POS_WIDTH;
	localparam int TW     = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int MAG_W  = PW + 1;
	localparam int MW     = (MAG_W > 32) ? MAG_W : 32;
	localparam int AW0    = 2 * MAG_W + 2;
	localparam int AW     = (AW0 > 50) ? AW0 : 50;
	localparam int RW     = AW / 2;
	localparam int SW     = RW + 3;
	localparam int NCH    = (MW + 15) / 16;
	localparam int KW     = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int SQ_CH  = (MAG_W + 15) / 16;
	localparam int CNT_W  = $clog2(RW);
	localparam int DW     = wpf3d_pkg::DIR_W;
	localparam int CW     = wpf3d_pkg::COORD_W;
	localparam logic [8:0]    MAXV    = 9'(MAX_WAYPOINTS);
	localparam logic [KW-1:0] MV_LAST = KW'(1);
	localparam logic [KW-1:0] SQ_LAST = KW'(SQ_CH - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MOVE, ST_MVADD, ST_SQN, ST_SQO, ST_CMP, ST_ARD,
		ST_SQV, ST_SQLD, ST_SQRT, ST_DIVI, ST_DIV, ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [CW-1:0]               spd_q   [3];
	logic [CW-1:0]               start_q [3];
	logic [wpf3d_pkg::PLEN_W-1:0] plen_q;

	// Waypoint table and its registered read word
	logic [3*PW-1:0] mem [MAX_WAYPOINTS];
	logic [3*PW-1:0] rd_q;
	logic            rd_en;
	logic [TW-1:0]   rd_addr;
	logic            wr_en;

	// Working state
	logic [TW-1:0]  tgt_q;
	logic [DW-1:0]  dir_q [3];
	logic [PW-1:0]  p_q   [3];
	logic [PW-1:0]  n_q   [3];
	logic [1:0]     ax_q;
	logic [KW-1:0]  k_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]  dn_q;
	logic [AW-1:0]  sv_q;
	logic [RW:0]    rem_q;
	logic [RW-1:0]  root_q;
	logic [RW:0]    rdv_q;
	logic [16:0]    qd_q;

	// Output register
	logic          ov_q;
	logic [CW-1:0] ox_q, oy_q, oz_q;
	logic [wpf3d_pkg::TGT_OUT_W-1:0] ot_q;

	// Combinational datapath signals
	logic [8:0]     len9;
	logic [8:0]     nxt9;
	logic [TW-1:0]  tgt_nxt;
	logic [PW-1:0]  wsel, xsel;
	logic [PW:0]    vw;
	logic           vneg;
	logic [MAG_W-1:0] vmag;
	logic [DW-1:0]  dsel, dabs;
	logic [16:0]    dmag;
	logic [CW-1:0]  ssel, smag;
	logic           mneg;
	logic [AW-1:0]  mv_sum;
	logic [PW-1:0]  dmp;
	logic [PW-1:0]  n_new;
	logic [MW-1:0]  mac_a;
	logic [NCH*16-1:0] mac_b, mac_bsh;
	logic [wpf3d_pkg::DIGIT_W-1:0] mac_digit;
	logic           mac_en, mac_first;
	logic [AW-1:0]  acc;
	logic [SW-1:0]  sub_x, sub_y, sub_d;
	logic           sub_bo, sub_ge;
	logic [16:0]    qn;
	logic [DW-1:0]  dir_new;
	logic           res_take;
	logic           cmd_take;
	logic           sq_state;
	logic           out_load;

	assign cmd_take = cmd.valid && cmd.ready;
	assign res_take = res.valid && res.ready;
	assign sq_state = (state_q == ST_SQN) || (state_q == ST_SQO) || (state_q == ST_SQV);
	assign out_load = (state_q == ST_DONE) && (!ov_q || res.ready);

	// Effective path length and the wrapped next target
	assign len9    = ({4'b0, plen_q} > MAXV) ? MAXV : {4'b0, plen_q};
	assign nxt9    = 9'(tgt_q) + 9'd1;
	assign tgt_nxt = (nxt9 >= len9) ? '0 : TW'(nxt9);

	// Vector from the selected point to the waypoint on the current axis
	assign wsel = rd_q[ax_q*PW +: PW];
	assign xsel = (state_q == ST_SQO) ? p_q[ax_q] : n_q[ax_q];
	assign vw   = {wsel[PW-1], wsel} - {xsel[PW-1], xsel};
	assign vneg = vw[PW];
	assign vmag = vneg ? (~vw + MAG_W'(1)) : vw;

	// Direction and speed magnitudes of the current axis
	assign dsel = dir_q[ax_q];
	assign dabs = dsel[DW-1] ? (~dsel + DW'(1)) : dsel;
	assign dmag = dabs[16:0];
	assign ssel = spd_q[ax_q];
	assign smag = ssel[CW-1] ? (~ssel + CW'(1)) : ssel;
	assign mneg = dsel[DW-1] ^ ssel[CW-1];

	// Scale the product down, rounding toward minus infinity, and add
	assign mv_sum = acc + (mneg ? AW'(16'hFFFF) : '0);
	assign dmp    = PW'(mv_sum >> wpf3d_pkg::FRAC_W);
	assign n_new  = p_q[ax_q] + (mneg ? (~dmp + PW'(1)) : dmp);

	// Multiplier operand selection
	always_comb begin
		if (state_q == ST_MOVE) begin
			mac_a = MW'(smag);
			mac_b = (NCH*16)'(dmag);
		end else begin
			mac_a = MW'(vmag);
			mac_b = (NCH*16)'(vmag);
		end
	end
	assign mac_bsh   = mac_b >> {k_q, 4'b0000};
	assign mac_digit = mac_bsh[wpf3d_pkg::DIGIT_W-1:0];
	assign mac_en    = (state_q == ST_MOVE) || sq_state;
	assign mac_first = (state_q == ST_MOVE) ? (k_q == '0) : ((ax_q == 2'd0) && (k_q == '0));

	wpf3d_mac #(
		.MW (MW),
		.AW (AW),
		.KW (KW)
	) u_mac (
		.clk   (clk),
		.en    (mac_en),
		.first (mac_first),
		.a     (mac_a),
		.digit (mac_digit),
		.k     (k_q),
		.acc   (acc)
	);

	// Shared compare-subtract for square root and division steps
	always_comb begin
		case (state_q)
			ST_SQRT: begin
				sub_x = SW'({rem_q, sv_q[AW-1 -: 2]});
				sub_y = SW'({root_q, 2'b01});
			end
			ST_DIVI: begin
				sub_x = SW'(vmag);
				sub_y = SW'(root_q);
			end
			ST_DIV: begin
				sub_x = SW'({rdv_q, 1'b0});
				sub_y = SW'(root_q);
			end
			default: begin
				sub_x = '0;
				sub_y = '0;
			end
		endcase
	end
	assign {sub_bo, sub_d} = {1'b0, sub_x} - {1'b0, sub_y};
	assign sub_ge          = !sub_bo;

	// Quotient after the last division step, with the vector's sign
	assign qn      = {qd_q[15:0], sub_ge};
	assign dir_new = vneg ? (~{1'b0, qn} + DW'(1)) : {1'b0, qn};

	// Waypoint table read and write ports
	assign wr_en   = cmd_take && (cmd.opcode == wpf3d_pkg::OP_LOAD)
		&& (9'(cmd.waypoint_slot) < MAXV);
	assign rd_en   = (cmd_take && ((cmd.opcode == wpf3d_pkg::OP_STEP)
		|| (cmd.opcode == wpf3d_pkg::OP_RESTART))) || (state_q == ST_ARD);
	assign rd_addr = (state_q == ST_IDLE && cmd.opcode == wpf3d_pkg::OP_RESTART) ? '0 : tgt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[TW'(cmd.waypoint_slot)] <= {PW'(cmd.coord_z), PW'(cmd.coord_y),
				PW'(cmd.coord_x)};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				spd_q[i]   <= '0;
				start_q[i] <= '0;
			end
			plen_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				wpf3d_pkg::CFG_SPEED_X:  spd_q[0]   <= cfg.data;
				wpf3d_pkg::CFG_SPEED_Y:  spd_q[1]   <= cfg.data;
				wpf3d_pkg::CFG_SPEED_Z:  spd_q[2]   <= cfg.data;
				wpf3d_pkg::CFG_START_X:  start_q[0] <= cfg.data;
				wpf3d_pkg::CFG_START_Y:  start_q[1] <= cfg.data;
				wpf3d_pkg::CFG_START_Z:  start_q[2] <= cfg.data;
				wpf3d_pkg::CFG_PATH_LEN: plen_q     <= cfg.data[wpf3d_pkg::PLEN_W-1:0];
				default: ;
			endcase
		end
	end
	assign cfg.ready = 1'b1;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tgt_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				dir_q[i] <= '0;
			end
			ov_q    <= 1'b0;
			ax_q    <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			// Fill the output register, or free it once the word is taken
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (res_take) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				// Decode a command word
				ST_IDLE: begin
					if (cmd_take) begin
						ax_q  <= '0;
						k_q   <= '0;
						p_q[0] <= PW'(cmd.coord_x);
						p_q[1] <= PW'(cmd.coord_y);
						p_q[2] <= PW'(cmd.coord_z);
						case (cmd.opcode)
							wpf3d_pkg::OP_STEP: begin
								n_q[0] <= PW'(cmd.coord_x);
								n_q[1] <= PW'(cmd.coord_y);
								n_q[2] <= PW'(cmd.coord_z);
								state_q <= (len9 != '0) ? ST_MOVE : ST_DONE;
							end
							wpf3d_pkg::OP_RESTART: begin
								for (int i = 0; i < 3; i++) begin
									n_q[i] <= PW'(signed'(start_q[i]));
								end
								tgt_q <= '0;
								if (len9 != '0) begin
									state_q <= ST_SQV;
								end else begin
									state_q <= ST_DONE;
									for (int i = 0; i < 3; i++) begin
										dir_q[i] <= '0;
									end
								end
							end
							default: begin
								for (int i = 0; i < 3; i++) begin
									n_q[i] <= '0;
								end
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				// Multiply direction by speed, one digit a cycle
				ST_MOVE: begin
					if (k_q == MV_LAST) begin
						state_q <= ST_MVADD;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				// Add the scaled step to the position
				ST_MVADD: begin
					n_q[ax_q] <= n_new;
					k_q       <= '0;
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= ST_SQN;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= ST_MOVE;
					end
				end
				// Squared distance sums
				ST_SQN, ST_SQO, ST_SQV: begin
					if (state_q == ST_SQO && ax_q == 2'd0 && k_q == '0) begin
						dn_q <= acc;
					end
					if (k_q == SQ_LAST) begin
						k_q <= '0;
						if (ax_q == 2'd2) begin
							ax_q <= '0;
							case (state_q)
								ST_SQN:  state_q <= ST_SQO;
								ST_SQO:  state_q <= ST_CMP;
								default: state_q <= ST_SQLD;
							endcase
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				// Advance the target when the step moved away from it
				ST_CMP: begin
					if (dn_q > acc) begin
						tgt_q   <= tgt_nxt;
						state_q <= ST_ARD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_ARD: begin
					state_q <= ST_SQV;
				end
				// Start the square root
				ST_SQLD: begin
					sv_q    <= acc;
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				// One root bit a cycle
				ST_SQRT: begin
					rem_q  <= sub_ge ? sub_d[RW:0] : sub_x[RW:0];
					root_q <= {root_q[RW-2:0], sub_ge};
					sv_q   <= sv_q << 2;
					if (cnt_q == CNT_W'(RW - 1)) begin
						ax_q    <= '0;
						state_q <= ST_DIVI;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				// First quotient bit; zero length gives zero direction
				ST_DIVI: begin
					if (root_q == '0) begin
						for (int i = 0; i < 3; i++) begin
							dir_q[i] <= '0;
						end
						state_q <= ST_DONE;
					end else begin
						qd_q    <= {16'b0, sub_ge};
						rdv_q   <= sub_ge ? sub_d[RW:0] : (RW+1)'(vmag);
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				// Restoring division, one quotient bit a cycle
				ST_DIV: begin
					qd_q  <= qn;
					rdv_q <= sub_ge ? sub_d[RW:0] : {rdv_q[RW-1:0], 1'b0};
					if (cnt_q == CNT_W'(15)) begin
						dir_q[ax_q] <= dir_new;
						if (ax_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= ST_DIVI;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				// Hand the word to the output register once it is free
				ST_DONE: begin
					if (out_load) begin
						ox_q    <= CW'(signed'(n_q[0]));
						oy_q    <= CW'(signed'(n_q[1]));
						oz_q    <= CW'(signed'(n_q[2]));
						ot_q    <= wpf3d_pkg::TGT_OUT_W'(tgt_q);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd.ready      = (state_q == ST_IDLE);
	assign res.valid      = ov_q;
	assign res.new_x      = ox_q;
	assign res.new_y      = oy_q;
	assign res.new_z      = oz_q;
	assign res.target_now = ot_q;

	`WPF3D_ASSERT_NXT(a_busy_after_accept, cmd.valid && cmd.ready, state_q != ST_IDLE, "command accepted but sequencer stayed idle")
	`WPF3D_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, root_q != '0, "division by zero length")
	`WPF3D_ASSERT_IMP(a_dir_unit, 1'b1, $signed(dir_q[0]) <= 65536 && $signed(dir_q[0]) >= -65536 && $signed(dir_q[1]) <= 65536 && $signed(dir_q[1]) >= -65536 && $signed(dir_q[2]) <= 65536 && $signed(dir_q[2]) >= -65536, "direction component beyond unit length")
endmodule

@@ bench/tb_waypoint_path_follower_3d_unit.sv @@
// Self-checking testbench for the waypoint path follower: directed and random command words.
module tb_waypoint_path_follower_3d_unit;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int TAIL_CYCLES = 300;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [3:0]         tgt;
	} pos_word_t;

	logic clk;
	logic arst_n;

	wpf3d_cmd_if cmd();
	wpf3d_res_if res();
	wpf3d_cfg_if cfg();

	waypoint_path_follower_3d_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res),
		.cfg    (cfg)
	);

	// Predictor copy of the block's registers and state
	logic signed [31:0] spd_x, spd_y, spd_z;
	logic signed [31:0] home_x, home_y, home_z;
	logic [4:0]         route_len;
	longint             wp_x [16];
	longint             wp_y [16];
	longint             wp_z [16];
	logic [3:0]         aim_idx;
	logic signed [17:0] heading_x, heading_y, heading_z;

	pos_word_t pending_pos[$];
	int        errors;
	int        cycles;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        stall_hold;

	// Last predicted position, used to build trajectories
	logic signed [31:0] track_x, track_y, track_z;

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL waypoint_path_follower_3d_unit");
			$finish;
		end
	end

	function automatic logic [127:0] dist_sq(longint dx, longint dy, longint dz);
		logic signed [127:0] ax, ay, az;
		ax = dx;
		ay = dy;
		az = dz;
		return ax * ax + ay * ay + az * az;
	endfunction

	function automatic logic [63:0] root_floor(logic [127:0] s);
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] cc;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			cc = {64'd0, c} * {64'd0, c};
			if (cc <= s)
				r = c;
		end
		return r;
	endfunction

	function automatic logic signed [17:0] unit_part(longint v, logic [63:0] h);
		logic [127:0] a;
		logic [127:0] q;
		a = (v < 0) ? -v : v;
		q = (a << 16) / {64'd0, h};
		return (v < 0) ? -$signed(q[17:0]) : $signed(q[17:0]);
	endfunction

	// Point the heading from (qx,qy,qz) toward waypoint idx
	task automatic point_toward(int idx, longint qx, longint qy, longint qz);
		longint      vx, vy, vz;
		logic [63:0] h;
		vx = wp_x[idx] - qx;
		vy = wp_y[idx] - qy;
		vz = wp_z[idx] - qz;
		h = root_floor(dist_sq(vx, vy, vz));
		if (h == 0) begin
			heading_x = '0;
			heading_y = '0;
			heading_z = '0;
		end else begin
			heading_x = unit_part(vx, h);
			heading_y = unit_part(vy, h);
			heading_z = unit_part(vz, h);
		end
	endtask

	function automatic longint advance_axis(longint p, logic signed [17:0] d,
			logic signed [31:0] s);
		longint             delta;
		longint             sum;
		logic signed [31:0] w;
		delta = (longint'(d) * longint'(s)) >>> 16;
		sum = p + delta;
		w = sum[31:0];
		return longint'(w);
	endfunction

	// Compute the result word of one command and update predictor state
	task automatic predict_move(wpf3d_pkg::op_t op, logic [3:0] slot, logic signed [31:0] cx,
			logic signed [31:0] cy, logic signed [31:0] cz);
		pos_word_t pw;
		int        span;
		int        t;
		longint    nx, ny, nz;
		span = (route_len > 16) ? 16 : route_len;
		pw.x = '0;
		pw.y = '0;
		pw.z = '0;
		case (op)
			wpf3d_pkg::OP_STEP: begin
				nx = cx;
				ny = cy;
				nz = cz;
				if (span > 0) begin
					t = aim_idx;
					nx = advance_axis(cx, heading_x, spd_x);
					ny = advance_axis(cy, heading_y, spd_y);
					nz = advance_axis(cz, heading_z, spd_z);
					if (dist_sq(wp_x[t] - nx, wp_y[t] - ny, wp_z[t] - nz) >
							dist_sq(wp_x[t] - cx, wp_y[t] - cy, wp_z[t] - cz)) begin
						t = aim_idx + 1;
						if (t >= span)
							t = 0;
						aim_idx = t[3:0];
						point_toward(t, nx, ny, nz);
					end
				end
				pw.x = nx[31:0];
				pw.y = ny[31:0];
				pw.z = nz[31:0];
			end
			wpf3d_pkg::OP_LOAD: begin
				wp_x[slot] = cx;
				wp_y[slot] = cy;
				wp_z[slot] = cz;
			end
			wpf3d_pkg::OP_RESTART: begin
				aim_idx = '0;
				if (span > 0) begin
					point_toward(0, home_x, home_y, home_z);
				end else begin
					heading_x = '0;
					heading_y = '0;
					heading_z = '0;
				end
				pw.x = home_x;
				pw.y = home_y;
				pw.z = home_z;
			end
			default: ;
		endcase
		pw.tgt = aim_idx;
		if (op == wpf3d_pkg::OP_STEP || op == wpf3d_pkg::OP_RESTART) begin
			track_x = pw.x;
			track_y = pw.y;
			track_z = pw.z;
		end
		pending_pos.push_back(pw);
	endtask

	// Offer one command word, wait for it to be taken, then predict it
	task automatic send_word(wpf3d_pkg::op_t op, logic [3:0] slot, logic signed [31:0] cx,
			logic signed [31:0] cy, logic signed [31:0] cz);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid         <= 1'b1;
		cmd.opcode        <= op;
		cmd.waypoint_slot <= slot;
		cmd.coord_x       <= cx;
		cmd.coord_y       <= cy;
		cmd.coord_z       <= cz;
		@(negedge clk);
		while (!cmd.ready)
			@(negedge clk);
		@(posedge clk);
		predict_move(op, slot, cx, cy, cz);
	endtask

	// Drop valid and wait until every result is back
	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		wait (pending_pos.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [wpf3d_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(negedge clk);
		while (!cfg.ready)
			@(negedge clk);
		@(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			wpf3d_pkg::CFG_SPEED_X:  spd_x = value;
			wpf3d_pkg::CFG_SPEED_Y:  spd_y = value;
			wpf3d_pkg::CFG_SPEED_Z:  spd_z = value;
			wpf3d_pkg::CFG_START_X:  home_x = value;
			wpf3d_pkg::CFG_START_Y:  home_y = value;
			wpf3d_pkg::CFG_START_Z:  home_z = value;
			wpf3d_pkg::CFG_PATH_LEN: route_len = value[4:0];
			default: ;
		endcase
		// Leave valid low before the next word
		@(posedge clk);
	endtask

	task automatic write_all(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
			logic [31:0] hx, logic [31:0] hy, logic [31:0] hz, logic [4:0] len);
		write_reg(wpf3d_pkg::CFG_SPEED_X, sx);
		write_reg(wpf3d_pkg::CFG_SPEED_Y, sy);
		write_reg(wpf3d_pkg::CFG_SPEED_Z, sz);
		write_reg(wpf3d_pkg::CFG_START_X, hx);
		write_reg(wpf3d_pkg::CFG_START_Y, hy);
		write_reg(wpf3d_pkg::CFG_START_Z, hz);
		write_reg(wpf3d_pkg::CFG_PATH_LEN, {27'd0, len});
	endtask

	// Mostly near-origin Q16.16 values, sometimes any 32-bit pattern
	function automatic logic [31:0] pick_coord();
		if ($urandom_range(99) < 12)
			return $urandom;
		return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
	endfunction

	function automatic logic [31:0] pick_speed();
		if ($urandom_range(99) < 15)
			return $urandom;
		return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
	endfunction

	// Directed corners: empty path, extremes, zero heading, shrunk path
	task automatic test_directed();
		wpf3d_pkg::op_t op;
		send_word(wpf3d_pkg::OP_NOP, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(wpf3d_pkg::OP_STEP, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		for (int s = 0; s < 16; s++)
			send_word(wpf3d_pkg::OP_LOAD, s[3:0], pick_coord(), pick_coord(), pick_coord());
		drain();
		write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 5'd31);
		send_word(wpf3d_pkg::OP_RESTART, 4'd0, 32'd0, 32'd0, 32'd0);
		send_word(wpf3d_pkg::OP_STEP, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(wpf3d_pkg::OP_STEP, 4'd0, track_x, track_y, track_z);
		// waypoint 0 on the start position gives a zero heading
		send_word(wpf3d_pkg::OP_LOAD, 4'd0, home_x, home_y, home_z);
		send_word(wpf3d_pkg::OP_RESTART, 4'd0, 32'd0, 32'd0, 32'd0);
		send_word(wpf3d_pkg::OP_STEP, 4'd0, track_x, track_y, track_z);
		drain();
		write_reg(wpf3d_pkg::CFG_PATH_LEN, 32'd0);
		send_word(wpf3d_pkg::OP_RESTART, 4'd0, 32'd0, 32'd0, 32'd0);
		send_word(wpf3d_pkg::OP_STEP, 4'd3, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000);
		drain();
		write_reg(wpf3d_pkg::CFG_PATH_LEN, 32'd16);
		op = wpf3d_pkg::OP_STEP;
		for (int i = 0; i < 3; i++)
			send_word(op, 4'd0, pick_coord(), pick_coord(), pick_coord());
		drain();
		// stale target beyond the shrunk length
		write_reg(wpf3d_pkg::CFG_PATH_LEN, 32'd1);
		send_word(wpf3d_pkg::OP_STEP, 4'd0, pick_coord(), pick_coord(), pick_coord());
		drain();
	endtask

	// One random phase: fresh registers, then mostly trajectory steps
	task automatic run_random_phase(int items, int corner);
		int r;
		logic [4:0] len;
		len = ($urandom_range(9) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
		if (corner == 1)
			write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
				32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5'd0);
		else if (corner == 2)
			write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd16);
		else
			write_all(pick_speed(), pick_speed(), pick_speed(),
				pick_coord(), pick_coord(), pick_coord(), len);
		send_word(wpf3d_pkg::OP_RESTART, 4'd0, 32'd0, 32'd0, 32'd0);
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(99);
			if (r < 62) begin
				if ($urandom_range(9) == 0)
					send_word(wpf3d_pkg::OP_STEP, 4'($urandom),
						track_x + 32'($urandom_range(0, 255)),
						track_y, track_z - 32'($urandom_range(0, 255)));
				else
					send_word(wpf3d_pkg::OP_STEP, 4'($urandom), track_x, track_y, track_z);
			end else if (r < 72)
				send_word(wpf3d_pkg::OP_LOAD, 4'($urandom), pick_coord(), pick_coord(),
					pick_coord());
			else if (r < 80)
				send_word(wpf3d_pkg::OP_RESTART, 4'($urandom), $urandom, $urandom, $urandom);
			else if (r < 84)
				send_word(wpf3d_pkg::OP_NOP, 4'($urandom), $urandom, $urandom, $urandom);
			else
				send_word(wpf3d_pkg::OP_STEP, 4'($urandom), pick_coord(), pick_coord(),
					pick_coord());
		end
		drain();
	endtask

	task automatic test_random();
		for (int p = 0; p < 9; p++) begin
			if (p < 3) begin
				send_idle_pct = 23;
				recv_idle_pct = 88;
			end else if (p < 6) begin
				send_idle_pct = 88;
				recv_idle_pct = 23;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			run_random_phase(145, (p == 2) ? 1 : (p == 5) ? 2 : 0);
		end
	endtask

	// Receiver holds off while commands keep coming, so the input stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_all(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
			32'd0, 32'd0, 32'd0, 5'd4);
		stall_hold = 400;
		for (int i = 0; i < 12; i++)
			send_word((i % 3 == 0) ? wpf3d_pkg::OP_LOAD : wpf3d_pkg::OP_NOP, 4'(i),
				pick_coord(), pick_coord(), pick_coord());
		drain();
	endtask

	// Receiver ready
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each taken result word with the oldest prediction
	always @(negedge clk) begin
		pos_word_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_pos.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word x=%h y=%h z=%h t=%0d", $time,
					res.new_x, res.new_y, res.new_z, res.target_now);
			end else begin
				want = pending_pos.pop_front();
				if (res.new_x !== want.x || res.new_y !== want.y ||
						res.new_z !== want.z || res.target_now !== want.tgt) begin
					errors++;
					$display("%0t: mismatch expected x=%h y=%h z=%h t=%0d actual x=%h y=%h z=%h t=%0d",
						$time, want.x, want.y, want.z, want.tgt,
						res.new_x, res.new_y, res.new_z, res.target_now);
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.opcode = wpf3d_pkg::OP_NOP;
		cmd.waypoint_slot = '0;
		cmd.coord_x = '0;
		cmd.coord_y = '0;
		cmd.coord_z = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		errors = 0;
		cycles = 0;
		stall_hold = 0;
		send_idle_pct = 23;
		recv_idle_pct = 88;
		spd_x = '0; spd_y = '0; spd_z = '0;
		home_x = '0; home_y = '0; home_z = '0;
		route_len = '0;
		aim_idx = '0;
		heading_x = '0; heading_y = '0; heading_z = '0;
		track_x = '0; track_y = '0; track_z = '0;
		for (int i = 0; i < 16; i++) begin
			wp_x[i] = 0;
			wp_y[i] = 0;
			wp_z[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random();
		test_backpressure();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending_pos.size() == 0)
			$display("PASS waypoint_path_follower_3d_unit");
		else
			$display("FAIL waypoint_path_follower_3d_unit");
		$finish;
	end
endmodule
